[hw/rtl/base64url_stream_decoder_unit_macros.svh]
// ============================================================================
// Assertion macros for the base64url stream decoder
// Shared concurrent assertion forms used by the decoder's modules.
// ============================================================================
`ifndef BASE64URL_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64URL_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/b64_pkg.sv]
// ============================================================================
// Base64url decoder package
// Shared types, constants and the character to sextet mapping.
// ============================================================================
package b64_pkg;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusBadChar = 2'd1;
   localparam logic [1:0] StatusBadLen  = 2'd2;

   localparam logic [7:0] PadChar    = 8'h3D;
   localparam logic [7:0] DashChar   = 8'h2D;
   localparam logic [7:0] UnderChar  = 8'h5F;
   localparam logic [7:0] UpperBase  = 8'h41;
   localparam logic [7:0] LowerBase  = 8'h61;
   localparam logic [7:0] DigitBase  = 8'h30;
   localparam logic [7:0] LowerOfs   = 8'd26;
   localparam logic [7:0] DigitOfs   = 8'd52;
   localparam logic [5:0] DashSextet  = 6'd62;
   localparam logic [5:0] UnderSextet = 6'd63;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // One decoded group or one error report, as handed from front to back.
   typedef struct packed {
      logic [23:0] data;    // three bytes, first byte in the upper bits
      logic [1:0]  cnt;     // number of bytes to emit, 1 to 3
      logic        eom;     // last byte closes the message
      logic [1:0]  status;
   } cmd_type;

   // Returns {valid, sextet}. Padding maps to a valid zero sextet.
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [6:0] r;
      r = '0;
      if (c inside {[8'h41:8'h5A]}) begin
         r = {1'b1, 6'(c - UpperBase)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         r = {1'b1, 6'(c - LowerBase + LowerOfs)};
      end else if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 6'(c - DigitBase + DigitOfs)};
      end else if (c == DashChar) begin
         r = {1'b1, DashSextet};
      end else if (c == UnderChar) begin
         r = {1'b1, UnderSextet};
      end else if (c == PadChar) begin
         r = {1'b1, 6'd0};
      end
      return r;
   endfunction

endpackage

[hw/rtl/base64url_stream_decoder_unit.sv]
// ============================================================================
// Base64url stream decoder
// Decodes a URL-safe base64 character stream into bytes with error status.
// ============================================================================
// The block takes one character per clock cycle on the request side and
// gives one decoded byte per clock cycle on the result side while that side
// is ready. The front end classifies each character in the cycle it is
// accepted and, on every fourth character or on an error, posts one command
// into a four-entry queue; the byte emitter then presents its bytes one per
// output cycle (three bytes for a full group, fewer in a padded final group,
// one for an error report). Four characters produce at most three bytes, so
// the sustained rate is one request per cycle. The first byte of a group
// passes through the queue and the result register. Requests stall only
// when the queue is full, which happens when the result side is held back.
module base64url_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // last_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast    // end_of_message
);

   logic             push;
   logic             pop;
   logic             q_full;
   logic             head_valid;
   b64_pkg::cmd_type wr_cmd;
   b64_pkg::cmd_type head;

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .cmd        (wr_cmd)
   );

   b64_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .wr_cmd     (wr_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hw/rtl/b64_front.sv]
// ============================================================================
// Base64url decoder front end
// Accepts characters, gathers sextets and posts groups or errors to the queue.
// ============================================================================
module b64_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] char_in
   input  logic             req_tlast,   // last_char
   input  logic             q_full,
   output logic             push,
   output b64_pkg::cmd_type cmd
);

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic        third_pad_ff, third_pad_in;
   logic        discard_ff, discard_in;

   logic        accept;
   logic        emit;
   logic [6:0]  map;
   logic [23:0] full;
   logic [1:0]  n_bytes;
   logic        is_pad;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign map        = b64_pkg::char_to_sextet(req_tdata);
   assign is_pad     = (req_tdata == b64_pkg::PadChar);
   assign full       = {acc_ff, map[5:0]};

   always_comb begin
      n_bytes = 2'd3;
      if (req_tlast && is_pad) begin
         n_bytes = n_bytes - 2'd1;
      end
      if (req_tlast && third_pad_ff) begin
         n_bytes = n_bytes - 2'd1;
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      third_pad_in = third_pad_ff;
      discard_in   = discard_ff;
      emit         = 1'b0;
      cmd.data     = '0;
      cmd.cnt      = 2'd1;
      cmd.eom      = 1'b1;
      cmd.status   = b64_pkg::StatusOk;
      if (accept) begin
         if (discard_ff) begin
            if (req_tlast) begin
               acc_in       = '0;
               pos_in       = '0;
               third_pad_in = 1'b0;
               discard_in   = 1'b0;
            end
         end else if (req_tlast && pos_ff != 2'd3) begin
            // A short final group outranks a bad final character.
            emit         = 1'b1;
            cmd.status   = b64_pkg::StatusBadLen;
            acc_in       = '0;
            pos_in       = '0;
            third_pad_in = 1'b0;
            discard_in   = 1'b0;
         end else if (!map[6]) begin
            emit         = 1'b1;
            cmd.status   = b64_pkg::StatusBadChar;
            acc_in       = '0;
            pos_in       = '0;
            third_pad_in = 1'b0;
            discard_in   = !req_tlast;
         end else if (pos_ff != 2'd3) begin
            acc_in = {acc_ff[11:0], map[5:0]};
            if (pos_ff == 2'd2) begin
               third_pad_in = is_pad;
            end
            pos_in = pos_ff + 2'd1;
         end else begin
            emit         = 1'b1;
            cmd.data     = full;
            cmd.cnt      = n_bytes;
            cmd.eom      = req_tlast;
            acc_in       = '0;
            pos_in       = '0;
            third_pad_in = 1'b0;
         end
      end
   end

   assign push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= '0;
         third_pad_ff <= 1'b0;
         discard_ff   <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         third_pad_ff <= third_pad_in;
         discard_ff   <= discard_in;
      end
   end

`include "base64url_stream_decoder_unit_macros.svh"

   `B64_ASSERT_NEXT(a_discard_group_clear, clock, reset, accept && emit && cmd.status != b64_pkg::StatusOk, pos_ff == 2'd0 && acc_ff == 18'd0, "group not cleared after an error")

endmodule

[hw/rtl/b64_queue.sv]
// ============================================================================
// Base64url decoder command queue
// Short first-in first-out buffer between the front end and the byte emitter.
// ============================================================================
module b64_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64_pkg::cmd_type wr_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output b64_pkg::cmd_type head
);

   b64_pkg::cmd_type                  mem_ff [b64_pkg::QueueDepth];
   logic [b64_pkg::QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [b64_pkg::QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [b64_pkg::QueueCntW-1:0]     cnt_ff, cnt_in;

   assign full       = (cnt_ff == b64_pkg::QueueCntW'(b64_pkg::QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + b64_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + b64_pkg::QueuePtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + b64_pkg::QueueCntW'(push) - b64_pkg::QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

`include "base64url_stream_decoder_unit_macros.svh"

   `B64_ASSERT_NOW(a_no_overflow, clock, reset, push, !full, "push into a full queue")
   `B64_ASSERT_NOW(a_no_underflow, clock, reset, pop, head_valid, "pop from an empty queue")

endmodule

[hw/rtl/b64_back.sv]
// ============================================================================
// Base64url decoder byte emitter
// Walks the head command byte by byte into a registered result stage.
// ============================================================================
module b64_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  b64_pkg::cmd_type head,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] data_byte
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast    // end_of_message
);

   logic [1:0] k_ff, k_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] status_ff, status_in;
   logic       eom_ff, eom_in;

   logic       out_free;
   logic       load;
   logic       last_byte;
   logic [7:0] sel_byte;

   assign out_free  = !vld_ff || rsp_tready;
   assign load      = out_free && head_valid;
   assign last_byte = (k_ff == 2'(head.cnt - 2'd1));
   assign pop       = load && last_byte;

   always_comb begin
      case (k_ff)
         2'd0:    sel_byte = head.data[23:16];
         2'd1:    sel_byte = head.data[15:8];
         default: sel_byte = head.data[7:0];
      endcase
   end

   always_comb begin
      k_in      = k_ff;
      vld_in    = vld_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      eom_in    = eom_ff;
      if (out_free) begin
         vld_in = load;
      end
      if (load) begin
         k_in      = last_byte ? 2'd0 : k_ff + 2'd1;
         byte_in   = sel_byte;
         status_in = head.status;
         eom_in    = head.eom && last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         vld_ff <= 1'b0;
      end else begin
         k_ff   <= k_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      eom_ff    <= eom_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = eom_ff;

`include "base64url_stream_decoder_unit_macros.svh"

   `B64_ASSERT_NOW(a_index_in_range, clock, reset, head_valid, k_ff < head.cnt, "byte index past the command's byte count")
   `B64_ASSERT_NOW(a_error_shape, clock, reset, vld_ff && status_ff != b64_pkg::StatusOk, byte_ff == 8'd0 && eom_ff, "error result must carry zero data and close the message")

endmodule
